### rtl/tawu_pkg.sv
// Package for the tar archive entry walker.
// Holds beat structs, parse phase enum, class codes and block geometry.
// No dependencies.
package tawu_pkg;

  localparam int BLOCK_BYTES       = 512;
  localparam int OFF_W             = $clog2(BLOCK_BYTES);
  localparam int SIZE_DIGITS       = 11;
  localparam int SIZE_W            = 3 * SIZE_DIGITS;
  localparam int SIZE_FIELD_AT     = 124;
  localparam int ENTRY_IDX_W       = 16;
  localparam int ENTRY_COUNT_BITS_DEF = 16;

  localparam logic [7:0] DIGIT_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_SEVEN = 8'h37;

  localparam logic [OFF_W-1:0] OFF_LAST       = OFF_W'(BLOCK_BYTES - 1);
  localparam logic [OFF_W-1:0] OFF_SIZE_FIRST = OFF_W'(SIZE_FIELD_AT);
  localparam logic [OFF_W-1:0] OFF_SIZE_END   = OFF_W'(SIZE_FIELD_AT + SIZE_DIGITS);

  localparam logic [1:0] CLASS_HEADER  = 2'd0;
  localparam logic [1:0] CLASS_PAYLOAD = 2'd1;
  localparam logic [1:0] CLASS_PAD     = 2'd2;
  localparam logic [1:0] CLASS_END     = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_END    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]             byte_class;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [OFF_W-1:0]       block_offset;
    logic [SIZE_W-1:0]      entry_size;
    logic                   size_valid;
    logic                   end_of_archive;
    logic                   digit_error;
  } out_beat_t;

endpackage

### rtl/tawu_in_reg.sv
// Input holding register for the tar walker.
// Captures one input beat and releases it when the parse stage advances.
// Depends on tawu_pkg.
module tawu_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tawu_pkg::in_beat_t in_data,
  output logic               in_stall,
  input  logic               advance,
  output logic               hold_valid,
  output tawu_pkg::in_beat_t hold_data
);

  logic               valid_r, valid_nxt;
  tawu_pkg::in_beat_t data_r;
  logic               load;

  // Refill when empty or when the held beat moves on this cycle.
  assign load      = !valid_r || advance;
  assign valid_nxt = load ? in_valid : valid_r;
  assign in_stall  = valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

### rtl/tawu_parse.sv
// Parse state and per-byte classification for the tar walker.
// Holds phase, block offset, size accumulator, payload count and entry count.
// Depends on tawu_pkg.
module tawu_parse #(
  parameter int ENTRY_COUNT_BITS = tawu_pkg::ENTRY_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tawu_pkg::in_beat_t  beat,
  output tawu_pkg::out_beat_t result
);

  localparam int OW = tawu_pkg::OFF_W;
  localparam int SW = tawu_pkg::SIZE_W;
  localparam int CW = ENTRY_COUNT_BITS;

  tawu_pkg::phase_t phase_r, phase_nxt, phase_cur;
  logic [OW-1:0]    off_r, off_nxt, off_cur;
  logic [SW-1:0]    acc_r, acc_nxt, acc_cur, acc_base, acc_dig;
  logic [SW-1:0]    left_r, left_nxt, left_cur, left_dec;
  logic [CW-1:0]    cnt_r, cnt_nxt, cnt_cur;
  logic             err_r, err_nxt, err_cur, err_base;

  logic       last, first, end_mark, in_field, is_octal, left_zero_after;
  logic [7:0] b;
  logic [1:0] cls;
  logic       size_ok;

  // Restart takes the byte as offset zero of a fresh header.
  assign phase_cur = beat.restart ? tawu_pkg::PH_HEADER : phase_r;
  assign off_cur   = beat.restart ? '0 : off_r;
  assign acc_cur   = beat.restart ? '0 : acc_r;
  assign left_cur  = beat.restart ? '0 : left_r;
  assign cnt_cur   = beat.restart ? '0 : cnt_r;
  assign err_cur   = beat.restart ? 1'b0 : err_r;

  assign b        = beat.archive_byte;
  assign first    = (off_cur == '0);
  assign last     = (off_cur == tawu_pkg::OFF_LAST);
  assign end_mark = first && (b == 8'h00);
  assign in_field = (off_cur >= tawu_pkg::OFF_SIZE_FIRST) &&
                    (off_cur <  tawu_pkg::OFF_SIZE_END);
  assign is_octal = (b >= tawu_pkg::DIGIT_ZERO) && (b <= tawu_pkg::DIGIT_SEVEN);

  // Clear the accumulator and error flag at a header's first byte.
  assign acc_base = first ? '0 : acc_cur;
  assign err_base = first ? 1'b0 : err_cur;
  // Shift in one octal digit; a bad digit counts as zero.
  assign acc_dig  = {acc_base[SW-4:0], (is_octal ? b[2:0] : 3'b000)};

  assign left_dec        = left_cur - SW'(1);
  assign left_zero_after = (left_cur == '0) || (left_dec == '0);

  // Next phase.
  always_comb begin
    phase_nxt = phase_cur;
    case (phase_cur)
      tawu_pkg::PH_HEADER: begin
        if (end_mark) begin
          phase_nxt = tawu_pkg::PH_END;
        end else if (last && (acc_nxt != '0)) begin
          phase_nxt = tawu_pkg::PH_DATA;
        end
      end
      tawu_pkg::PH_DATA: begin
        if (last && left_zero_after) begin
          phase_nxt = tawu_pkg::PH_HEADER;
        end
      end
      default: phase_nxt = tawu_pkg::PH_END;
    endcase
  end

  // Datapath and per-byte outputs.
  always_comb begin
    acc_nxt  = acc_cur;
    left_nxt = left_cur;
    cnt_nxt  = cnt_cur;
    err_nxt  = err_cur;
    cls      = tawu_pkg::CLASS_END;
    size_ok  = 1'b0;
    case (phase_cur)
      tawu_pkg::PH_HEADER: begin
        cls     = end_mark ? tawu_pkg::CLASS_END : tawu_pkg::CLASS_HEADER;
        acc_nxt = acc_base;
        err_nxt = err_base;
        if (!end_mark) begin
          if (in_field) begin
            acc_nxt = acc_dig;
            err_nxt = err_base || !is_octal;
          end
          if (last) begin
            size_ok  = 1'b1;
            left_nxt = acc_nxt;
            if (acc_nxt == '0) begin
              cnt_nxt = cnt_cur + CW'(1);
            end
          end
        end
      end
      tawu_pkg::PH_DATA: begin
        if (left_cur != '0) begin
          cls      = tawu_pkg::CLASS_PAYLOAD;
          left_nxt = left_dec;
        end else begin
          cls = tawu_pkg::CLASS_PAD;
        end
        if (last && left_zero_after) begin
          cnt_nxt = cnt_cur + CW'(1);
        end
      end
      default: cls = tawu_pkg::CLASS_END;
    endcase
  end

  assign off_nxt = last ? '0 : off_cur + OW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tawu_pkg::PH_HEADER;
      off_r   <= '0;
      acc_r   <= '0;
      left_r  <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    result.byte_class     = cls;
    result.entry_index    = tawu_pkg::ENTRY_IDX_W'(cnt_cur);
    result.block_offset   = off_cur;
    result.entry_size     = size_ok ? acc_nxt : '0;
    result.size_valid     = size_ok;
    result.end_of_archive = (phase_nxt == tawu_pkg::PH_END);
    result.digit_error    = err_nxt;
  end

endmodule

### rtl/tar_archive_entry_walker_unit.sv
// Tar archive entry walker: one archive byte in, one classified byte out.
// Path: each accepted beat passes the input register, then the result register;
// the parse update sits between them.
// Throughput: one byte per cycle through the single parse stage while out_stall is low.
// Reset: synchronous active-low rst_n empties both registers and returns the
// parser to header phase at offset zero with all counters cleared.
module tar_archive_entry_walker_unit #(
  parameter int ENTRY_COUNT_BITS = tawu_pkg::ENTRY_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tawu_pkg::in_beat_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output tawu_pkg::out_beat_t out_data,
  input  logic                out_stall
);

  logic                advance;
  logic                hold_valid;
  tawu_pkg::in_beat_t  hold_data;
  tawu_pkg::out_beat_t parse_result;
  logic                out_valid_r, out_valid_nxt;
  tawu_pkg::out_beat_t out_data_r;

  // The result register frees up when empty or when its beat is taken.
  // The held input beat is parsed in the same cycle it moves forward, so the
  // parse state updates exactly once per delivered beat.
  assign advance = !out_valid_r || !out_stall;

  tawu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  // Header, data and end phases; octal size shift-in; payload countdown.
  tawu_parse #(
    .ENTRY_COUNT_BITS (ENTRY_COUNT_BITS)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (hold_valid && advance),
    .beat   (hold_data),
    .result (parse_result)
  );

  // Hold the result until taken; load the next one as soon as it leaves.
  assign out_valid_nxt = advance ? hold_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      out_data_r <= parse_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A size report only appears on the last byte of a header block.
  a_size_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.size_valid) |->
      (out_data.block_offset == tawu_pkg::OFF_LAST &&
       out_data.byte_class == tawu_pkg::CLASS_HEADER))
    else $error("size_valid off the last header byte");

  // Entry size is zero whenever it is not reported.
  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.size_valid) |-> (out_data.entry_size == '0))
    else $error("entry_size nonzero without size_valid");

  // End-class bytes always carry the end flag.
  a_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.byte_class == tawu_pkg::CLASS_END) |->
      out_data.end_of_archive)
    else $error("end class without end_of_archive");

  // Input stalls only while a beat is held and the result side is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (hold_valid && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule
